FILE: src/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// immediate-implication check on a clock, reset disabled
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication check
`define ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

FILE: src/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Payload types, constants and round functions.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word_0;
        logic [31:0] digest_word_1;
        logic [31:0] digest_word_2;
        logic [31:0] digest_word_3;
        logic [31:0] digest_word_4;
        logic [31:0] digest_word_5;
        logic [31:0] digest_word_6;
        logic [31:0] digest_word_7;
    } t_out_item;

    // byte source selected for a block buffer write
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } t_src;

    // controller -> datapath
    typedef struct packed {
        logic       wr_en;
        t_src       src;
        logic [5:0] wr_pos;
        logic [2:0] len_idx;
        logic       cnt_inc;
        logic       start;
        logic       round_en;
        logic       finish_blk;
        logic       reset_cv;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [5:0] pos;
        logic [5:0] round;
    } t_status;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [255:0] IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

FILE: src/sha_dp.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, byte count, message schedule window and round registers.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_dp import sha_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic [7:0] i_byte,
    input  wire t_cmd      i_cmd,
    output t_status        o_stat,
    output logic [255:0]   o_digest
);
    // block buffer kept as 16 big-endian words, written one byte at a time
    logic [31:0]  r_buf [16];
    logic [60:0]  r_cnt;
    logic [31:0]  r_w [16];
    logic [31:0]  r_v [8];
    logic [255:0] r_cv;
    logic [5:0]   r_round;
    logic [7:0]   wr_data;
    logic [63:0]  bits;
    logic [31:0]  s0, s1, w_new, t1, t2, e, a;

    assign bits = {r_cnt, 3'b000};

    always_comb begin
        case (i_cmd.src)
            SRC_DATA: wr_data = i_byte;
            SRC_PAD:  wr_data = PAD_BYTE;
            SRC_ZERO: wr_data = 8'h00;
            SRC_LEN:  wr_data = bits[8*(7-i_cmd.len_idx) +: 8];
            default:  wr_data = 8'h00;
        endcase
    end

    // schedule: window of 16 words, w[0] is the current round word
    assign s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = s1 + r_w[9] + s0 + r_w[0];

    assign e  = r_v[4];
    assign a  = r_v[0];
    assign t1 = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + round_k(r_round) + r_w[0];
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_buf[i_cmd.wr_pos[5:2]][31 - 8*i_cmd.wr_pos[1:0] -: 8] <= wr_data;
        end
        if (i_cmd.start) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= r_buf[i];
            end
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_cv[255-32*i -: 32];
            end
        end else if (i_cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_cv    <= IV;
            r_round <= '0;
        end else begin
            if (i_cmd.reset_cv) begin
                r_cnt <= '0;
                r_cv  <= IV;
            end else begin
                if (i_cmd.cnt_inc) begin
                    r_cnt <= r_cnt + 61'd1;
                end
                if (i_cmd.finish_blk) begin
                    for (int i = 0; i < 8; i++) begin
                        r_cv[255-32*i -: 32] <= r_cv[255-32*i -: 32] + r_v[i];
                    end
                end
            end
            if (i_cmd.start) begin
                r_round <= '0;
            end else if (i_cmd.round_en) begin
                r_round <= r_round + 6'd1;
            end
        end
    end

    assign o_stat.pos   = r_cnt[5:0];
    assign o_stat.round = r_round;
    assign o_digest     = r_cv;
endmodule
`default_nettype wire

FILE: src/sha_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loads, padding, compressions and digest delivery.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_ctrl import sha_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output logic          o_stall,
    input  wire t_status  i_stat,
    output t_cmd          o_cmd,
    output logic          o_out_valid,
    input  wire logic     i_out_stall
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_ROUND = 7'b0000100,
        S_SUM   = 7'b0001000,
        S_PAD   = 7'b0010000,
        S_LEN   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic       r_fin, n_fin;     // message end pending
    logic       r_last, n_last;   // compression in flight is the final one
    logic [5:0] r_p, n_p;         // padding write position
    logic       acc;

    assign o_stall     = (r_state != S_IDLE);
    assign acc         = i_valid && !o_stall;
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_last  = r_last;
        n_p     = r_p;
        o_cmd   = '0;
        o_cmd.src = SRC_DATA;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_fin = i_item.message_end;
                    if (i_item.byte_present) begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wr_pos  = i_stat.pos;
                        o_cmd.cnt_inc = 1'b1;
                        if (i_stat.pos == 6'd63) begin
                            n_last  = 1'b0;
                            n_state = S_START;
                        end else if (i_item.message_end) begin
                            n_p     = i_stat.pos + 6'd1;
                            n_state = S_PAD;
                        end
                    end else if (i_item.message_end) begin
                        n_p     = i_stat.pos;
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                // 0x80 at the count position, zeros after it
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_pos = r_p;
                o_cmd.src    = (r_p == i_stat.pos) ? SRC_PAD : SRC_ZERO;
                n_p = r_p + 6'd1;
                if (r_p == 6'd63) begin
                    n_last  = 1'b0;
                    n_state = S_START;
                end else if (r_p == 6'd55) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_pos  = r_p;
                o_cmd.src     = SRC_LEN;
                o_cmd.len_idx = r_p[2:0];
                n_p = r_p + 6'd1;
                if (r_p == 6'd63) begin
                    n_last  = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (i_stat.round == 6'd63) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.finish_blk = 1'b1;
                if (r_last) begin
                    n_state = S_OUT;
                end else if (r_fin) begin
                    // spill block done, or full block just before the end:
                    // padding restarts at position 0 (0x80 only if count is there)
                    n_p     = 6'd0;
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    o_cmd.reset_cv = 1'b1;
                    n_fin   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= 1'b0;
            r_last  <= 1'b0;
            r_p     <= '0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_last  <= n_last;
            r_p     <= n_p;
        end
    end
endmodule
`default_nettype wire

FILE: src/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and delivers the 256-bit digest at message end.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_valid / o_stall, payload i_item): one transfer may carry a
//  message byte (byte_present) and may end the message (message_end).
//  Output channel (o_valid / i_stall, payload o_item): one transfer per
//  message, the eight digest words in big-endian word order.
//  Throughput: one byte per cycle inside a block. The 64th byte of a block
//  starts a compression (load, 64 rounds at one per cycle on one shared round
//  unit, chaining add) during which input is stalled.
//  Message end: padding writes one byte per cycle from the pad position up to
//  63, then a compression; a second pad pass over the whole block and a second
//  compression follow when the length does not fit the current block.
//  o_valid rises the cycle after the final chaining add and the digest is
//  shown until the receiver takes it.
//  Reset (synchronous, i_rst_n low) loads the standard initial value and
//  clears the byte count; the block buffer holds no reset value.
//  While the receiver stalls, the digest holds and no input is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sha256_byte_stream_hasher import sha_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);
    t_cmd         cmd;
    t_status      stat;
    logic [255:0] digest;

    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_stall     (o_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall)
    );

    sha_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_item.data_byte),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_digest (digest)
    );

    assign o_item = digest;

    // no input while a digest is offered
    `ASSERT_IMP(a_no_in_while_out, i_clk, i_rst_n, o_valid, o_stall)
    // chaining value only reloads when the digest is taken
    `ASSERT_IMP(a_reset_cv_on_take, i_clk, i_rst_n, cmd.reset_cv, o_valid && !i_stall)
    // a held digest stays put
    `ASSERT_NXT(a_digest_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(o_item))
endmodule
`default_nettype wire
